FILE: hw/rtl/bpu_pkg.sv
// Shared types, constants and helpers of the billboard particle update block.
package bpu_pkg;

    localparam int MAX_LIVE_DEF = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_TIME = 3'd0,
        REG_EYE_POS    = 3'd1,
        REG_EYE_UP     = 3'd2,
        REG_EYE_RIGHT  = 3'd3,
        REG_LIVE_COUNT = 3'd4,
        REG_FAR_DIST   = 3'd5,
        REG_CEILING    = 3'd6
    } t_cfg_idx;

    localparam logic [9:0]  FRAME_TIME_RST = 10'd16;
    localparam logic [10:0] FAR_DIST_RST   = 11'd64;
    localparam logic [10:0] CEILING_RST    = 11'd32;

    localparam logic [5:0] CUT_HIGH = 6'd51;
    localparam logic [5:0] CUT_MID  = 6'd41;
    localparam logic [5:0] CUT_LOW  = 6'd26;
    localparam logic [5:0] CUT_NONE = 6'd0;

    localparam logic signed [11:0] ONE_COLOR = 12'sd512;
    localparam logic signed [15:0] ONE_VEC   = 16'sd16384;

    // floor(n/1000) = (n * DIV_MUL) >> DIV_SHIFT for n < 2^26
    localparam int          DIV_SHIFT = 36;
    localparam logic [26:0] DIV_MUL   = 27'd68719477;
    localparam logic [25:0] HALF_K    = 26'd500;
    localparam int          LANES     = 9;

    typedef struct packed {
        logic [47:0] color;
        logic [47:0] position;
        logic [31:0] extent;
        logic [47:0] color_rate;
        logic        faces_camera;
    } t_part;

    typedef struct packed {
        logic [47:0] corner_position;
        logic [1:0]  corner_index;
        logic [47:0] new_color;
        logic [47:0] new_position;
        logic [31:0] new_extent;
        logic [47:0] new_color_rate;
        logic        last_corner;
    } t_corner;

    function automatic logic [15:0] sat16(input logic signed [20:0] v);
        logic [15:0] res;
        if (v > 21'sd32767) begin
            res = 16'h7FFF;
        end else if (v < -21'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    function automatic logic [11:0] sat12(input logic signed [17:0] v);
        logic [11:0] res;
        if (v > 18'sd2047) begin
            res = 12'h7FF;
        end else if (v < -18'sd2048) begin
            res = 12'h800;
        end else begin
            res = v[11:0];
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/bpu_front.sv
// Time scaling, culling and integration pipeline (three register stages).
module bpu_front
    import bpu_pkg::*;
#(
    parameter int MAX_LIVE = MAX_LIVE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [303:0] i_data,
    input  logic         i_faces,
    input  logic [9:0]   i_frame_time,
    input  logic [47:0]  i_eye_pos,
    input  logic [12:0]  i_live_count,
    input  logic [10:0]  i_far_dist,
    input  logic [10:0]  i_ceiling,
    output logic         o_valid,
    input  logic         i_ready,
    output t_part        o_part
);
    localparam int TH_HI  = MAX_LIVE * 7 / 8;
    localparam int TH_MID = MAX_LIVE * 3 / 4;
    localparam int TH_LOW = MAX_LIVE / 2;

    // stage A
    logic                r_a_v;
    logic [25:0]         r_a_mag [LANES];
    logic                r_a_neg [LANES];
    logic [32:0]         r_a_dsq [3];
    logic [21:0]         r_a_far2;
    logic [5:0]          r_a_cut;
    logic                r_a_halve;
    logic [47:0]         r_a_pos, r_a_color, r_a_rate, r_a_after;
    logic [31:0]         r_a_ext;
    logic [15:0]         r_a_vy;
    logic                r_a_faces;
    // stage B
    logic                r_b_v;
    logic signed [16:0]  r_b_q [LANES];
    logic [34:0]         r_b_dist;
    logic [29:0]         r_b_rad2;
    logic [5:0]          r_b_cut;
    logic [47:0]         r_b_pos, r_b_color, r_b_rate, r_b_after;
    logic [31:0]         r_b_ext;
    logic [15:0]         r_b_vy;
    logic                r_b_faces;
    // stage C
    logic                r_c_v;
    t_part               r_c_part;

    logic a_rdy, b_rdy, c_rdy;
    assign c_rdy   = !r_c_v || i_ready;
    assign b_rdy   = !r_b_v || c_rdy;
    assign a_rdy   = !r_a_v || b_rdy;
    assign o_ready = a_rdy;
    assign o_valid = r_c_v;
    assign o_part  = r_c_part;

    // stage A logic
    logic signed [15:0] op [LANES];
    logic [25:0]        n_mag [LANES];
    logic               n_neg [LANES];
    logic [32:0]        n_dsq [3];
    logic [5:0]         n_cut;
    logic               n_halve;

    always_comb begin
        logic signed [26:0] prod;
        logic signed [26:0] absv;
        logic signed [16:0] d;
        logic signed [33:0] sq;
        for (int j = 0; j < 4; j++) begin
            op[j] = 16'($signed(i_data[208 + 12*j +: 12]));
        end
        for (int j = 0; j < 3; j++) begin
            op[4+j] = i_data[48 + 16*j +: 16];
        end
        for (int j = 0; j < 2; j++) begin
            op[7+j] = i_data[128 + 16*j +: 16];
        end
        for (int j = 0; j < LANES; j++) begin
            prod     = $signed({{11{op[j][15]}}, op[j]}) * $signed({17'b0, i_frame_time});
            n_neg[j] = prod[26];
            absv     = prod[26] ? -prod : prod;
            n_mag[j] = absv[25:0] + HALF_K;
        end
        for (int j = 0; j < 3; j++) begin
            d        = 17'($signed(i_data[16*j +: 16])) - 17'($signed(i_eye_pos[16*j +: 16]));
            sq       = d * d;
            n_dsq[j] = sq[32:0];
        end
        if (32'(i_live_count) > TH_HI) begin
            n_cut = CUT_HIGH; n_halve = 1'b1;
        end else if (32'(i_live_count) > TH_MID) begin
            n_cut = CUT_MID;  n_halve = 1'b1;
        end else if (32'(i_live_count) > TH_LOW) begin
            n_cut = CUT_LOW;  n_halve = 1'b0;
        end else begin
            n_cut = CUT_NONE; n_halve = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_rdy) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy) begin
            r_a_mag   <= n_mag;
            r_a_neg   <= n_neg;
            r_a_dsq   <= n_dsq;
            r_a_far2  <= 22'(i_far_dist) * 22'(i_far_dist);
            r_a_cut   <= n_cut;
            r_a_halve <= n_halve;
            r_a_pos   <= i_data[47:0];
            r_a_vy    <= i_data[79:64];
            r_a_ext   <= i_data[127:96];
            r_a_color <= i_data[207:160];
            r_a_rate  <= i_data[255:208];
            r_a_after <= i_data[303:256];
            r_a_faces <= i_faces;
        end
    end

    // stage B logic
    logic signed [16:0] n_q [LANES];

    always_comb begin
        logic [52:0] pr;
        logic [16:0] qm;
        for (int j = 0; j < LANES; j++) begin
            pr     = {27'b0, r_a_mag[j]} * {26'b0, DIV_MUL};
            qm     = pr[DIV_SHIFT+16:DIV_SHIFT];
            n_q[j] = r_a_neg[j] ? -$signed(qm) : $signed(qm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_rdy) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_rdy) begin
            r_b_q     <= n_q;
            r_b_dist  <= 35'(r_a_dsq[0]) + 35'(r_a_dsq[1]) + 35'(r_a_dsq[2]);
            r_b_rad2  <= r_a_halve ? {1'b0, r_a_far2, 7'b0} : {r_a_far2, 8'b0};
            r_b_cut   <= r_a_cut;
            r_b_pos   <= r_a_pos;
            r_b_vy    <= r_a_vy;
            r_b_ext   <= r_a_ext;
            r_b_color <= r_a_color;
            r_b_rate  <= r_a_rate;
            r_b_after <= r_a_after;
            r_b_faces <= r_a_faces;
        end
    end

    // stage C logic
    logic [11:0] nc [4];
    t_part       n_part;
    logic        n_keep;

    always_comb begin
        logic signed [16:0] py;
        logic signed [16:0] ceil_q;
        logic               fade, far_cull, ground, ceil_cull;
        for (int j = 0; j < 4; j++) begin
            nc[j] = sat12(18'($signed(r_b_color[12*j +: 12])) + 18'(r_b_q[j]));
        end
        for (int j = 0; j < 3; j++) begin
            n_part.position[16*j +: 16] =
                sat16(21'($signed(r_b_pos[16*j +: 16])) + 21'(r_b_q[4+j]));
        end
        for (int j = 0; j < 2; j++) begin
            n_part.extent[16*j +: 16] =
                sat16(21'($signed(r_b_ext[16*j +: 16])) + 21'(r_b_q[7+j]));
        end
        py        = 17'($signed(r_b_pos[31:16]));
        ceil_q    = $signed({2'b0, i_ceiling, 4'b0});
        fade      = r_b_rate[47] && ($signed(nc[3]) <= $signed({6'b0, r_b_cut}));
        far_cull  = r_b_dist > 35'(r_b_rad2);
        ground    = r_b_vy[15] && py[16];
        ceil_cull = !r_b_vy[15] && (r_b_vy != 16'd0) && (py > ceil_q);
        n_keep    = !(fade || far_cull || ground || ceil_cull);
        n_part.color_rate = r_b_rate;
        if ($signed(nc[3]) > ONE_COLOR) begin
            nc[3]             = ONE_COLOR;
            n_part.color_rate = r_b_after;
        end
        n_part.color        = {nc[3], nc[2], nc[1], nc[0]};
        n_part.faces_camera = r_b_faces;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (c_rdy) begin
            r_c_v <= r_b_v && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_rdy) begin
            r_c_part <= n_part;
        end
    end

endmodule

FILE: hw/rtl/bpu_corner.sv
// Quad offset products and four-corner emitter with output register.
module bpu_corner
    import bpu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_part       i_part,
    input  logic [47:0] i_eye_up,
    input  logic [47:0] i_eye_right,
    output logic        o_valid,
    input  logic        i_ready,
    output t_corner     o_corner
);
    logic               r_d_v;
    t_part              r_d_part;
    logic signed [31:0] r_d_a [3];
    logic signed [31:0] r_d_b [3];
    logic [1:0]         r_k;
    logic               r_o_v;
    t_corner            r_o;

    logic load, d_rdy;
    assign load    = r_d_v && (!r_o_v || i_ready);
    assign d_rdy   = !r_d_v || (load && (r_k == 2'd3));
    assign o_ready = d_rdy;
    assign o_valid = r_o_v;
    assign o_corner = r_o;

    logic signed [31:0] n_a [3];
    logic signed [31:0] n_b [3];

    always_comb begin
        logic signed [15:0] u, r;
        for (int j = 0; j < 3; j++) begin
            if (i_part.faces_camera) begin
                u = i_eye_up[16*j +: 16];
                r = i_eye_right[16*j +: 16];
            end else begin
                u = (j == 0) ? ONE_VEC : 16'sd0;
                r = (j == 2) ? ONE_VEC : 16'sd0;
            end
            n_a[j] = u * $signed(i_part.extent[31:16]);
            n_b[j] = r * $signed(i_part.extent[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_k   <= 2'd0;
        end else begin
            if (d_rdy) begin
                r_d_v <= i_valid;
                r_k   <= 2'd0;
            end else if (load) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_rdy) begin
            r_d_part <= i_part;
            r_d_a    <= n_a;
            r_d_b    <= n_b;
        end
    end

    t_corner n_o;

    always_comb begin
        logic signed [32:0] off;
        logic [32:0]        mag;
        logic [18:0]        qm;
        logic signed [19:0] q;
        logic               pos_a, pos_b;
        pos_a = r_k[1];
        pos_b = (r_k == 2'd1) || (r_k == 2'd2);
        for (int j = 0; j < 3; j++) begin
            off = (pos_a ? 33'(r_d_a[j]) : -33'(r_d_a[j]))
                + (pos_b ? 33'(r_d_b[j]) : -33'(r_d_b[j]));
            mag = (off[32] ? 33'(-off) : 33'(off)) + 33'd8192;
            qm  = mag[32:14];
            q   = off[32] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
            n_o.corner_position[16*j +: 16] =
                sat16(21'($signed(r_d_part.position[16*j +: 16])) + 21'(q));
        end
        n_o.corner_index   = r_k;
        n_o.new_color      = r_d_part.color;
        n_o.new_position   = r_d_part.position;
        n_o.new_extent     = r_d_part.extent;
        n_o.new_color_rate = r_d_part.color_rate;
        n_o.last_corner    = (r_k == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (load) begin
            r_o_v <= 1'b1;
        end else if (i_ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o <= n_o;
        end
    end

endmodule

FILE: hw/rtl/billboard_particle_update.sv
// Top level of the billboard particle update block: config registers and stream ports.
//
// Slave stream takes one particle word per handshake; tuser carries the
// camera-facing flag. Kept particles give four corner words on the master
// stream, one per cycle while m_axis_tready is high, tlast on the fourth;
// culled particles give none. An input word reaches the first corner word
// via three arithmetic stages, the offset product stage and the output register.
// Throughput: a new particle every cycle while particles are culled; a kept
// particle holds the corner emitter until its fourth corner is loaded into
// the output register, and only then can the emitter take the next particle.
// Config writes are registered; the user must make them while idle (not enforced).
// Reset is synchronous, active low: clears all valid bits and restores
// the config registers to their defaults.
// When the receiver stalls, the output word holds, the emitter holds its
// corner, and the stages behind it fill and then drop s_axis_tready.
module billboard_particle_update
    import bpu_pkg::*;
#(
    parameter int MAX_LIVE = MAX_LIVE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // position, velocity, extent, extent_rate, color, color_rate, color_rate_after
    input  logic [303:0]          s_axis_tdata,
    // faces_camera
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // corner_position, corner_index, new_color, new_position, new_extent,
    // new_color_rate, zero pad
    output logic [231:0]          m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [9:0]  r_frame_time;
    logic [47:0] r_eye_pos, r_eye_up, r_eye_right;
    logic [12:0] r_live_count;
    logic [10:0] r_far_dist, r_ceiling;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= FRAME_TIME_RST;
            r_eye_pos    <= '0;
            r_eye_up     <= '0;
            r_eye_right  <= '0;
            r_live_count <= '0;
            r_far_dist   <= FAR_DIST_RST;
            r_ceiling    <= CEILING_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_FRAME_TIME: r_frame_time <= i_cfg_data[9:0];
                REG_EYE_POS:    r_eye_pos    <= i_cfg_data[47:0];
                REG_EYE_UP:     r_eye_up     <= i_cfg_data[47:0];
                REG_EYE_RIGHT:  r_eye_right  <= i_cfg_data[47:0];
                REG_LIVE_COUNT: r_live_count <= i_cfg_data[12:0];
                REG_FAR_DIST:   r_far_dist   <= i_cfg_data[10:0];
                REG_CEILING:    r_ceiling    <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    logic    part_v, part_rdy;
    t_part   part;
    t_corner corner;

    bpu_front #(.MAX_LIVE(MAX_LIVE)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_faces      (s_axis_tuser),
        .i_frame_time (r_frame_time),
        .i_eye_pos    (r_eye_pos),
        .i_live_count (r_live_count),
        .i_far_dist   (r_far_dist),
        .i_ceiling    (r_ceiling),
        .o_valid      (part_v),
        .i_ready      (part_rdy),
        .o_part       (part)
    );

    bpu_corner u_corner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (part_v),
        .o_ready     (part_rdy),
        .i_part      (part),
        .i_eye_up    (r_eye_up),
        .i_eye_right (r_eye_right),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_corner    (corner)
    );

    assign m_axis_tdata = {6'b0, corner.new_color_rate, corner.new_extent,
                           corner.new_position, corner.new_color,
                           corner.corner_index, corner.corner_position};
    assign m_axis_tlast = corner.last_corner;

endmodule

FILE: hw/rtl/bpu_checker.sv
// Port-level checks of the billboard particle update block and their binding.
module bpu_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [231:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_last_on_fourth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[49:48] == 2'd3)))
        else $error("tlast not on corner three");

    a_corner_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[49:48] == $past(m_axis_tdata[49:48]) + 2'd1))
        else $error("corner sequence broken");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled word changed");

endmodule

bind billboard_particle_update bpu_checker u_bpu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
